>>> sv/rlbp_pkg.sv
// Shared types and constants for the RGB LED blink PWM block.
// No dependencies; every other file imports this package.

package rlbp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_FREQ  = 3'd1;
    localparam logic [2:0] REG_DUTY  = 3'd2;
    localparam logic [2:0] REG_RED   = 3'd3;
    localparam logic [2:0] REG_GREEN = 3'd4;
    localparam logic [2:0] REG_BLUE  = 3'd5;
    localparam logic [2:0] REG_TOP   = 3'd6;

    localparam logic [1:0] CH_RED  = 2'd0;
    localparam logic [1:0] CH_BLUE = 2'd2;

    localparam logic [16:0] FRAC_FULL  = 17'd65536;
    localparam logic [16:0] COUNT_MAX  = 17'd131071;
    localparam logic [9:0]  MS_PER_SEC = 10'd1000;
    localparam logic [7:0]  PCT_FULL   = 8'd100;
    localparam logic [9:0]  DUR_RESET  = 10'd500;

    // divider: 16 quotient bits, two per cycle
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = 16 / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LVL,
        ST_PER,
        ST_PER_W,
        ST_ON,
        ST_ON_W,
        ST_DUR,
        ST_STEP,
        ST_TMUL,
        ST_TDIV,
        ST_TWAIT,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CFG_WR,
        OP_CAP,
        OP_LVL_WR,
        OP_PER_START,
        OP_PER_SAVE,
        OP_ON_START,
        OP_DUR_WR,
        OP_STEP,
        OP_TICK_MUL,
        OP_TICK_START,
        OP_TICK_WR,
        OP_OUT_LOAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] ch;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

>>> sv/rlbp_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on rlbp_pkg. Caller guarantees quotient < 2^16.

module rlbp_div
    import rlbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          low_reg, low_next;
    logic [15:0]          dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [16:0] trial;
        rem_next = rem_reg;
        low_next = low_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial    = {rem_next, low_next[15]};
            low_next = {low_next[14:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = 16'(trial - {1'b0, dvs_reg});
                low_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[31:16];
            low_reg <= dividend[15:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

>>> sv/rlbp_ctrl.sv
// Sequencer for configuration updates and per-request work.
// Depends on rlbp_pkg; drives the datapath through cmd_t.

module rlbp_ctrl
    import rlbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  stat_t      stat,
    output cmd_t       cmd,
    output logic       in_stall,
    output logic       cfg_ready
);

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        REG_MODE, REG_FREQ, REG_DUTY: state_next = ST_PER;
                        REG_RED, REG_GREEN, REG_BLUE: state_next = ST_LVL;
                        default:                      state_next = ST_IDLE;
                    endcase
                end
                else if (in_valid)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_LVL:   state_next = ST_IDLE;
            ST_PER:   state_next = ST_PER_W;
            ST_PER_W: if (stat.div_done) state_next = ST_ON;
            ST_ON:    state_next = ST_ON_W;
            ST_ON_W:  if (stat.div_done) state_next = ST_DUR;
            ST_DUR:   state_next = ST_IDLE;
            ST_STEP:
            begin
                ch_next    = CH_RED;
                state_next = ST_TMUL;
            end
            ST_TMUL:  state_next = ST_TDIV;
            ST_TDIV:  state_next = ST_TWAIT;
            ST_TWAIT:
            begin
                if (stat.div_done)
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = (ch_reg == CH_BLUE) ? ST_FIN : ST_TMUL;
                end
            end
            ST_FIN:   if (stat.out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        cmd.ch = ch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                    cmd.op = OP_CFG_WR;
                else if (in_valid)
                    cmd.op = OP_CAP;
            end
            ST_LVL:   cmd.op = OP_LVL_WR;
            ST_PER:   cmd.op = OP_PER_START;
            ST_PER_W: if (stat.div_done) cmd.op = OP_PER_SAVE;
            ST_ON:    cmd.op = OP_ON_START;
            ST_ON_W:  if (stat.div_done) cmd.op = OP_DUR_WR;
            ST_STEP:  cmd.op = OP_STEP;
            ST_TMUL:  cmd.op = OP_TICK_MUL;
            ST_TDIV:  cmd.op = OP_TICK_START;
            ST_TWAIT: if (stat.div_done) cmd.op = OP_TICK_WR;
            ST_FIN:   if (stat.out_free) cmd.op = OP_OUT_LOAD;
            default:  cmd.op = OP_NONE;
        endcase
    end

    // config takes priority over a request in the same cycle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_RED;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

>>> sv/rlbp_dp.sv
// Datapath: config registers, levels, blink timer, compare scaling, output register.
// Depends on rlbp_pkg and rlbp_div.

module rlbp_dp
    import rlbp_pkg::*;
#(
    parameter int LEVELS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red_compare,
    output logic [15:0] green_compare,
    output logic [15:0] blue_compare,
    output logic        lit
);

    localparam logic [15:0] VMAX = 16'(LEVELS - 1);
    localparam logic [15:0] HALF = 16'((LEVELS - 1) / 2);

    // configuration
    logic        mode_reg;
    logic [15:0] freq_reg;
    logic [7:0]  duty_reg;
    logic [15:0] top_reg;

    // blink state
    logic [16:0] count_reg;
    logic        phase_reg;
    logic [9:0]  on_reg;
    logic [9:0]  off_reg;
    logic [9:0]  period_reg;

    logic [15:0] lvl_reg [3];
    logic [15:0] tick_reg [3];
    logic [32:0] fprod_reg;
    logic        fnz_reg;
    logic [1:0]  fch_reg;
    logic [31:0] tprod_reg;
    logic [15:0] elapsed_reg;

    logic        out_valid_reg;
    logic [15:0] out_r_reg, out_g_reg, out_b_reg;
    logic        out_lit_reg;

    logic        div_start;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_done;
    logic [15:0] div_q;

    logic [16:0] frac_sat;
    logic [16:0] lvl_round;
    logic [15:0] lvl_new;
    logic [15:0] freq_eff;
    logic [7:0]  duty_sat;
    logic [9:0]  on_q;
    logic [9:0]  off_raw;
    logic [15:0] lvl_sel;
    logic [15:0] tick_new;
    logic        lit_now;
    logic [9:0]  phase_len;
    logic [17:0] count_sum;
    logic [16:0] count_sat;

    assign frac_sat  = (cfg_data > FRAC_FULL) ? FRAC_FULL : cfg_data;
    assign lvl_round = 17'((fprod_reg + 33'd32768) >> 16);
    assign lvl_new   = (fnz_reg && lvl_round == '0) ? 16'd1 : lvl_round[15:0];

    assign freq_eff = (freq_reg == '0) ? 16'd1 : freq_reg;
    assign duty_sat = (duty_reg > PCT_FULL) ? PCT_FULL : duty_reg;
    assign on_q     = div_q[9:0];
    assign off_raw  = period_reg - on_q;

    always_comb
    begin
        case (cmd.ch)
            2'd0:    lvl_sel = lvl_reg[0];
            2'd1:    lvl_sel = lvl_reg[1];
            default: lvl_sel = lvl_reg[2];
        endcase
    end

    assign lit_now  = !mode_reg || phase_reg;
    assign tick_new = (lvl_sel == '0 || !lit_now) ? 16'd0
                    : (div_q == '0) ? 16'd1 : div_q;

    assign phase_len = phase_reg ? on_reg : off_reg;
    assign count_sum = {1'b0, count_reg} + {2'b00, elapsed_reg};
    assign count_sat = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[16:0];

    // divider operand select
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = tprod_reg;
        div_divisor  = VMAX;
        case (cmd.op)
            OP_PER_START:
            begin
                div_start    = 1'b1;
                div_dividend = {22'd0, MS_PER_SEC};
                div_divisor  = freq_eff;
            end
            OP_ON_START:
            begin
                div_start    = 1'b1;
                div_dividend = 32'(period_reg * duty_sat);
                div_divisor  = {8'd0, PCT_FULL};
            end
            OP_TICK_START:
            begin
                div_start = 1'b1;
            end
            default: div_start = 1'b0;
        endcase
    end

    rlbp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            freq_reg      <= 16'd1;
            duty_reg      <= 8'd50;
            top_reg       <= 16'd255;
            count_reg     <= '0;
            phase_reg     <= 1'b1;
            on_reg        <= DUR_RESET;
            off_reg       <= DUR_RESET;
            lvl_reg[0]    <= '0;
            lvl_reg[1]    <= '0;
            lvl_reg[2]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_CFG_WR:
                begin
                    case (cfg_index)
                        REG_MODE: mode_reg <= cfg_data[0];
                        REG_FREQ: freq_reg <= cfg_data[15:0];
                        REG_DUTY: duty_reg <= cfg_data[7:0];
                        REG_TOP:  top_reg  <= cfg_data[15:0];
                        default:  ;
                    endcase
                end
                OP_LVL_WR: lvl_reg[fch_reg] <= lvl_new;
                OP_DUR_WR:
                begin
                    on_reg    <= (on_q == '0 && duty_sat != '0) ? 10'd1 : on_q;
                    off_reg   <= (off_raw == '0 && duty_sat != PCT_FULL) ? 10'd1 : off_raw;
                    count_reg <= '0;
                    phase_reg <= 1'b1;
                end
                OP_STEP:
                begin
                    // static mode ignores elapsed time; one toggle at most
                    if (mode_reg)
                    begin
                        if (count_sat >= {7'd0, phase_len})
                        begin
                            count_reg <= '0;
                            phase_reg <= !phase_reg;
                        end
                        else
                        begin
                            count_reg <= count_sat;
                        end
                    end
                end
                OP_OUT_LOAD: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CFG_WR:
            begin
                fprod_reg <= 33'(frac_sat * VMAX);
                fnz_reg   <= (frac_sat != '0);
                fch_reg   <= 2'(cfg_index - REG_RED);
            end
            OP_CAP:      elapsed_reg <= elapsed_ms;
            OP_PER_SAVE: period_reg  <= (div_q == '0) ? 10'd1 : div_q[9:0];
            OP_TICK_MUL: tprod_reg   <= 32'(lvl_sel * top_reg) + {16'd0, HALF};
            OP_TICK_WR:  tick_reg[cmd.ch] <= tick_new;
            OP_OUT_LOAD:
            begin
                out_r_reg   <= tick_reg[0];
                out_g_reg   <= tick_reg[1];
                out_b_reg   <= tick_reg[2];
                out_lit_reg <= lit_now;
            end
            default: ;
        endcase
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign red_compare   = out_r_reg;
    assign green_compare = out_g_reg;
    assign blue_compare  = out_b_reg;
    assign lit           = out_lit_reg;

endmodule

>>> sv/rgb_led_blink_pwm_core.sv
// Top level of the RGB LED blink PWM block: controller plus datapath.
// Depends on rlbp_pkg, rlbp_ctrl, rlbp_dp (which holds rlbp_div).
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+-------------------------
//  in      | elapsed_ms[15:0]                         | in_valid / in_stall
//  out     | red/green/blue_compare[15:0], lit        | out_valid / out_stall
//  cfg     | cfg_index[2:0], cfg_data[16:0]           | cfg_valid / cfg_ready
//
// One request at a time: after acceptance the blink phase is updated, then the
// shared 2-bit-per-cycle divider (a start step, its iterations and a done step)
// is used once per color channel after a multiply step, and the result register
// is loaded; the next request is taken in the cycle after the load.
// The result sits in an output register, so the next request is taken while
// the previous result is still stalled; only the final load waits on it.
// Writes to mode, blink rate or duty hold cfg_ready low while the on/off
// durations are recomputed; color writes hold it low while the level is stored.
// Reset (rst_n, async low) restores the documented register values, a lit
// phase, zero levels and 500/500 ms durations.

module rgb_led_blink_pwm_core
    import rlbp_pkg::*;
#(
    parameter int LEVELS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] red_compare,
    output logic [15:0] green_compare,
    output logic [15:0] blue_compare,
    output logic        lit,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: decodes config writes and walks the per-request steps
    rlbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready)
    );

    // datapath: registers, blink timer, level and compare arithmetic
    rlbp_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .elapsed_ms    (elapsed_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red_compare   (red_compare),
        .green_compare (green_compare),
        .blue_compare  (blue_compare),
        .lit           (lit)
    );

endmodule

>>> sv/rlbp_chk.sv
// Port-level checks for rgb_led_blink_pwm_core, attached by bind.
// Depends on rlbp_pkg for register indexes.

module rlbp_chk
    import rlbp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] red_compare,
    input logic [15:0] green_compare,
    input logic [15:0] blue_compare,
    input logic        lit,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    // dark phase drives all compares to zero
    a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !lit |-> red_compare == '0 && green_compare == '0
                              && blue_compare == '0)
        else $error("nonzero compare in dark phase");

    // one request in flight: accepting one stalls the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !cfg_ready)
        else $error("request taken while previous one in progress");

    // program writes start a duration recompute
    a_prog_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == REG_MODE || cfg_index == REG_FREQ
                                   || cfg_index == REG_DUTY)
        |=> !cfg_ready ##1 !cfg_ready)
        else $error("config ready during duration recompute");

endmodule

bind rgb_led_blink_pwm_core rlbp_chk u_chk (.*);

>>> test/rgb_led_blink_pwm_core_tb.sv
// Self-checking testbench for rgb_led_blink_pwm_core: directed and random requests
// checked against a built-in predictor of the compare values and blink phase.
// Depends on rlbp_pkg and the rgb_led_blink_pwm_core RTL.

module rgb_led_blink_pwm_core_tb
    import rlbp_pkg::*;
();

    localparam int LEVELS       = 256;
    localparam int LVL_MAX      = LEVELS - 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        lit;
    } led_result_t;

    // DUT connections
    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] elapsed_ms;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] red_compare;
    logic [15:0] green_compare;
    logic [15:0] blue_compare;
    logic        lit;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // Shadow copy of the block's registers and blink state
    logic        mode_q;
    logic [15:0] freq_q;
    logic [7:0]  duty_q;
    logic [15:0] top_q;
    logic [15:0] red_lvl;
    logic [15:0] green_lvl;
    logic [15:0] blue_lvl;
    logic [16:0] since_toggle;
    logic        phase_lit;
    int          on_ms;
    int          off_ms;

    led_result_t expected_leds[$];  // predicted results, oldest first
    led_result_t got_leds;
    led_result_t want_leds;
    int          mismatches = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b0;    // enables random gaps on both channels

    rgb_led_blink_pwm_core #(
        .LEVELS(LEVELS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .elapsed_ms(elapsed_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red_compare(red_compare),
        .green_compare(green_compare),
        .blue_compare(blue_compare),
        .lit(lit),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q1.16 fraction to a level, rounded; nonzero input never gives level 0
    function automatic logic [15:0] frac_level(input logic [16:0] frac);
        longint f;
        longint v;
        f = (frac > FRAC_FULL) ? FRAC_FULL : frac;
        v = (f * LVL_MAX + 32768) >> 16;
        if (f > 0 && v == 0)
            v = 1;
        return v[15:0];
    endfunction

    // Level to compare ticks against the current timer top, min one tick for a nonzero level
    function automatic logic [15:0] level_ticks(input logic [15:0] lvl);
        longint l;
        longint t;
        if (lvl == 0)
            return '0;
        l = (lvl > LVL_MAX) ? LVL_MAX : lvl;
        t = (l * top_q + LVL_MAX / 2) / LVL_MAX;
        if (t == 0)
            t = 1;
        return t[15:0];
    endfunction

    // New on/off durations; restart in the lit phase
    function automatic void restart_blink();
        int f;
        int d;
        int per;
        f = (freq_q == 0) ? 1 : int'(freq_q);
        d = (duty_q > PCT_FULL) ? int'(PCT_FULL) : int'(duty_q);
        per = int'(MS_PER_SEC) / f;
        if (per == 0)
            per = 1;
        on_ms = per * d / int'(PCT_FULL);
        off_ms = per - on_ms;
        // a zero-length phase only survives at duty 0 or 100
        if (on_ms == 0 && d > 0)
            on_ms = 1;
        if (off_ms == 0 && d < int'(PCT_FULL))
            off_ms = 1;
        since_toggle = '0;
        phase_lit = 1'b1;
    endfunction

    function automatic void shadow_reset();
        mode_q = 1'b0;
        freq_q = 16'd1;
        duty_q = 8'd50;
        top_q = 16'd255;
        red_lvl = '0;
        green_lvl = '0;
        blue_lvl = '0;
        restart_blink();
    endfunction

    // Upper bits beyond each register's width are dropped, color data saturates; index 7 is a no-op
    function automatic void shadow_write(input logic [2:0] idx, input logic [16:0] data);
        case (idx)
            REG_MODE:
            begin
                mode_q = data[0];
                restart_blink();
            end
            REG_FREQ:
            begin
                freq_q = data[15:0];
                restart_blink();
            end
            REG_DUTY:
            begin
                duty_q = data[7:0];
                restart_blink();
            end
            REG_RED:   red_lvl = frac_level(data);
            REG_GREEN: green_lvl = frac_level(data);
            REG_BLUE:  blue_lvl = frac_level(data);
            REG_TOP:   top_q = data[15:0];
            default: ;
        endcase
    endfunction

    // Advance the blink phase by one request and form its result
    function automatic led_result_t predict_leds(input logic [15:0] ms);
        led_result_t r;
        int plen;
        int cnt;
        logic shown;
        if (mode_q)
        begin
            plen = phase_lit ? on_ms : off_ms;
            cnt = since_toggle + ms;
            if (cnt > COUNT_MAX)
                cnt = COUNT_MAX;
            // at most one toggle; leftover time is dropped
            if (cnt >= plen)
            begin
                cnt = 0;
                phase_lit = !phase_lit;
            end
            since_toggle = cnt[16:0];
        end
        shown = !mode_q || phase_lit;
        r.red = shown ? level_ticks(red_lvl) : '0;
        r.green = shown ? level_ticks(green_lvl) : '0;
        r.blue = shown ? level_ticks(blue_lvl) : '0;
        r.lit = shown;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    function automatic void log_mismatch(input string what, input led_result_t want,
                                         input led_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected r=%0d g=%0d b=%0d lit=%0b, ",
                     what, want.red, want.green, want.blue, want.lit,
                     "got r=%0d g=%0d b=%0d lit=%0b",
                     got.red, got.green, got.blue, got.lit);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_leds = '{red_compare, green_compare, blue_compare, lit};
            if (expected_leds.size() == 0)
                log_mismatch("no request pending", '0, got_leds);
            else
            begin
                want_leds = expected_leds.pop_front();
                if (got_leds !== want_leds)
                    log_mismatch("field", want_leds, got_leds);
            end
        end
    end

    // Random receiver stall bursts while idling is on
    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers; every task is entered and left just after a falling edge
    // ------------------------------------------------------------------

    // One elapsed-time request; valid stays high into the next call unless
    // that call opens a gap, so valid never drops and rises in one step
    task automatic send_elapsed(input logic [15:0] ms);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        elapsed_ms <= ms;
        do @(posedge clk); while (in_stall);
        expected_leds.push_back(predict_leds(ms));
        @(negedge clk);
    endtask

    // Close the request stream and wait until every result is back, so the
    // block is idle and registers may be written
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        shadow_write(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [16:0] pick_reg_data(input logic [2:0] idx);
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        case (idx)
            // low rates give long phases, high rates collapse to 1 ms
            REG_FREQ:  return roll < 5 ? 17'($urandom_range(0, 25)) : 17'($urandom);
            REG_DUTY:  return roll < 6 ? 17'($urandom_range(0, 120)) : 17'($urandom);
            REG_RED, REG_GREEN, REG_BLUE:
                return roll < 4 ? 17'($urandom_range(0, 400)) : 17'($urandom);
            REG_TOP:   return roll < 4 ? 17'($urandom_range(0, 300)) : 17'($urandom);
            default:   return 17'($urandom);
        endcase
    endfunction

    // Mostly steps well inside the current phase, so phases toggle often
    function automatic logic [15:0] pick_elapsed();
        int span;
        span = (on_ms > off_ms) ? on_ms : off_ms;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return '0;
            default: return 16'($urandom_range(0, span / 2 + 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: static mode, dark colors, lit
    task automatic test_reset_values();
        wait_drain();
        send_elapsed(16'd0);
        send_elapsed(16'hFFFF);
        send_elapsed(16'd1);
    endtask

    // Fraction rounding, saturation, minimum level, and timer top extremes
    task automatic test_color_levels();
        wait_drain();
        write_reg(REG_TOP, 17'd65535);
        write_reg(REG_RED, 17'd1);          // rounds to 0, forced to level 1
        write_reg(REG_GREEN, FRAC_FULL);
        write_reg(REG_BLUE, 17'h1FFFF);     // above full scale, saturates
        send_elapsed(16'd5);
        wait_drain();
        write_reg(REG_RED, 17'd0);
        write_reg(REG_GREEN, 17'd65535);
        write_reg(REG_BLUE, 17'd257);
        send_elapsed(16'd0);
        wait_drain();
        write_reg(REG_TOP, 17'd0);          // every nonzero level gives 1 tick
        send_elapsed(16'd0);
        wait_drain();
        write_reg(REG_TOP, 17'h10001);      // top 1, upper bit dropped
        write_reg(REG_RED, 17'd128);
        send_elapsed(16'd0);
        wait_drain();
        write_reg(3'd7, 17'h1FFFF);         // unused index, no effect
        write_reg(REG_TOP, 17'd255);
        send_elapsed(16'd3);
    endtask

    // Blink phase: minimum 1 ms phases, duty 0 and 100, freq 0, saturation
    task automatic test_blink_timing();
        wait_drain();
        write_reg(REG_MODE, 17'd1);
        write_reg(REG_FREQ, 17'd1000);      // 1 ms period, both phases 1 ms
        send_elapsed(16'd0);
        send_elapsed(16'd1);
        send_elapsed(16'd1);
        wait_drain();
        write_reg(REG_FREQ, 17'd0);         // treated as 1 Hz
        write_reg(REG_DUTY, 17'd0);         // empty lit phase lasts one request
        send_elapsed(16'd0);
        send_elapsed(16'd999);
        send_elapsed(16'd1);
        send_elapsed(16'd0);
        wait_drain();
        write_reg(REG_DUTY, 17'h1FFFF);     // 255, saturates at 100
        send_elapsed(16'hFFFF);
        send_elapsed(16'd0);
        wait_drain();
        write_reg(REG_FREQ, 17'd65535);     // period below 1 ms clamps to 1
        write_reg(REG_DUTY, 17'd100);
        send_elapsed(16'd0);
        send_elapsed(16'd0);
        wait_drain();
        write_reg(REG_MODE, 17'h1FFFE);     // static again, elapsed ignored
        send_elapsed(16'hFFFF);
    endtask

    // Phases of random register writes followed by random request streams
    task automatic test_random_traffic(input int items, input bit allow_idle);
        int sent;
        int writes;
        int burst;
        logic [2:0] idx;
        sent = 0;
        while (sent < items)
        begin
            wait_drain();
            idle_on = allow_idle && ($urandom_range(0, 4) != 0);
            writes = $urandom_range(1, 8);
            repeat (writes)
            begin
                idx = 3'($urandom_range(0, 7));
                write_reg(idx, pick_reg_data(idx));
            end
            burst = $urandom_range(5, 40);
            repeat (burst)
            begin
                send_elapsed(pick_elapsed());
                sent++;
            end
        end
    endtask

    // Final stretch at full rate: no gaps and no stalls
    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_traffic(200, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        elapsed_ms = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        shadow_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        test_reset_values();
        test_color_levels();
        test_blink_timing();
        test_random_traffic(1130, 1'b1);
        test_back_to_back();

        // every result back, then watch for anything extra
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
